### rtl/core/resource_budget_preemptive_scheduler_assert.svh
// assertion macros for the resource budget scheduler
`ifndef RESOURCE_BUDGET_PREEMPTIVE_SCHEDULER_ASSERT_SVH
`define RESOURCE_BUDGET_PREEMPTIVE_SCHEDULER_ASSERT_SVH
`ifndef ASSERT_OFF
`define RBPS_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("rbps assertion failed");
`define RBPS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbps implication failed");
`else
`define RBPS_ASSERT(lbl, expr)
`define RBPS_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

### rtl/core/rbps_pkg.sv
// shared types and constants of the resource budget scheduler
package rbps_pkg;
	localparam int SLOTS = 16;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int ENTRY_W = 64;
	localparam int IN_W = 48;
	localparam int OUT_W = 32;

	typedef enum logic [2:0] {
		KIND_ACCEPT = 3'd0,
		KIND_REJECT = 3'd1,
		KIND_FINISH = 3'd2,
		KIND_RUN    = 3'd3,
		KIND_TICK   = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CH_RD,
		ST_CH_WB,
		ST_SEL_START,
		ST_SC_RD,
		ST_SC_MUL1,
		ST_SC_MUL2,
		ST_SC_CMP,
		ST_GREEDY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [7:0]  task_id;
		logic [7:0]  prio;
		logic [15:0] length;
		logic [15:0] remaining;
		logic [15:0] need;
	} entry_t;
endpackage

### rtl/core/resource_budget_preemptive_scheduler.sv
// arrival: result in the cycle after the transfer; next item taken once the result
// can move on; tick: a charge pass over the slots, then up to SLOTS+1 selection passes
// through the one shared cross-multiply comparator, each pass reading the slots in turn
// through the single table read port and able to stall on the output; reset clears the
// slot flags, the budget register and the sequencer; no clearing pass
`include "resource_budget_preemptive_scheduler_assert.svh"
module resource_budget_preemptive_scheduler (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [15:0]                cfg_wdata,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// task_id, priority_req, run length, resource_need
	input  logic [rbps_pkg::IN_W-1:0]  s_axis_tdata,
	// mode
	input  logic                       s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// out_task, new_interval, resources_used, zero fill
	output logic [rbps_pkg::OUT_W-1:0] m_axis_tdata,
	// kind
	output logic [2:0]                 m_axis_tuser,
	output logic                       m_axis_tlast
);
	import rbps_pkg::*;

	state_t state_q, state_d;
	logic [CW-1:0] idx_q;
	logic [SW-1:0] slot;
	logic [SLOTS-1:0] valid_q, ran_last_q, picked_q, chosen_q;
	logic [15:0] total_q, left_q;

	logic ram_we, ram_re;
	logic [SW-1:0] ram_waddr, ram_raddr;
	entry_t ram_wdata, rd;

	logic [23:0] cand_pr_q, best_pr_q;
	logic [15:0] cand_l_q, best_l_q, cand_need_q, best_need_q;
	logic [7:0]  cand_task_q, best_task_q;
	logic [39:0] lhs_q, rhs_q;
	logic [SW-1:0] best_idx_q;
	logic best_found_q;

	logic out_valid_q, out_last_q, out_new_q;
	kind_t out_kind_q;
	logic [7:0] out_task_q;
	logic [15:0] out_used_q;

	logic can_emit, in_fire, emit, idx_end, fits, is_tick, reject;
	logic [SW-1:0] free_slot;
	logic [15:0] rem_dec;
	kind_t emit_kind;
	logic [7:0] emit_task;
	logic emit_new;

	assign slot = idx_q[SW-1:0];
	assign idx_end = (idx_q == CW'(SLOTS));
	assign can_emit = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && can_emit;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign is_tick = s_axis_tuser;
	assign rem_dec = rd.remaining - 16'd1;
	assign fits = best_need_q < left_q;
	assign reject = (s_axis_tdata[31:16] == 16'd0) || (&valid_q);

	always_comb begin
		free_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_slot = SW'(i);
		end
	end

	rbps_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && is_tick) state_d = ST_CH_RD;
			end
			ST_CH_RD: begin
				if (idx_end) state_d = ST_SEL_START;
				else if (valid_q[slot] && ran_last_q[slot]) state_d = ST_CH_WB;
			end
			ST_CH_WB: begin
				if (rem_dec != 16'd0 || can_emit) state_d = ST_CH_RD;
			end
			ST_SEL_START: state_d = ST_SC_RD;
			ST_SC_RD: begin
				if (idx_end) state_d = best_found_q ? ST_GREEDY : ST_DONE;
				else if (valid_q[slot] && !picked_q[slot]) state_d = ST_SC_MUL1;
			end
			ST_SC_MUL1: state_d = ST_SC_MUL2;
			ST_SC_MUL2: state_d = ST_SC_CMP;
			ST_SC_CMP: state_d = ST_SC_RD;
			ST_GREEDY: begin
				if (!fits || can_emit) state_d = ST_SEL_START;
			end
			ST_DONE: begin
				if (can_emit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// table access and result selection
	always_comb begin
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_waddr = slot;
		ram_raddr = slot;
		ram_wdata = rd;
		emit = 1'b0;
		emit_kind = KIND_TICK;
		emit_task = 8'd0;
		emit_new = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ram_waddr = free_slot;
				ram_wdata.task_id = s_axis_tdata[7:0];
				ram_wdata.prio = s_axis_tdata[15:8];
				ram_wdata.length = s_axis_tdata[31:16];
				ram_wdata.remaining = s_axis_tdata[31:16];
				ram_wdata.need = s_axis_tdata[47:32];
				if (in_fire && !is_tick) begin
					ram_we = !reject;
					emit = 1'b1;
					emit_kind = reject ? KIND_REJECT : KIND_ACCEPT;
					emit_task = s_axis_tdata[7:0];
				end
			end
			ST_CH_RD: begin
				ram_re = !idx_end && valid_q[slot] && ran_last_q[slot];
			end
			ST_CH_WB: begin
				ram_wdata.remaining = rem_dec;
				if (rem_dec != 16'd0) begin
					ram_we = 1'b1;
				end else begin
					emit = can_emit;
					emit_kind = KIND_FINISH;
					emit_task = rd.task_id;
				end
			end
			ST_SC_RD: begin
				ram_re = !idx_end && valid_q[slot] && !picked_q[slot];
			end
			ST_GREEDY: begin
				emit = fits && can_emit;
				emit_kind = KIND_RUN;
				emit_task = best_task_q;
				emit_new = !ran_last_q[best_idx_q];
			end
			ST_DONE: begin
				emit = can_emit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			valid_q <= '0;
			ran_last_q <= '0;
			picked_q <= '0;
			chosen_q <= '0;
			total_q <= '0;
			left_q <= '0;
			best_found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) total_q <= cfg_wdata;
			if (emit) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire && is_tick) begin
						idx_q <= '0;
						picked_q <= '0;
						chosen_q <= '0;
						left_q <= total_q;
					end else if (in_fire && !reject) begin
						valid_q[free_slot] <= 1'b1;
						ran_last_q[free_slot] <= 1'b0;
					end
				end
				ST_CH_RD: begin
					if (!idx_end && !(valid_q[slot] && ran_last_q[slot])) idx_q <= idx_q + 1'b1;
				end
				ST_CH_WB: begin
					if (rem_dec != 16'd0) begin
						idx_q <= idx_q + 1'b1;
					end else if (can_emit) begin
						valid_q[slot] <= 1'b0;
						ran_last_q[slot] <= 1'b0;
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SEL_START: begin
					idx_q <= '0;
					best_found_q <= 1'b0;
				end
				ST_SC_RD: begin
					if (!idx_end && !(valid_q[slot] && !picked_q[slot])) idx_q <= idx_q + 1'b1;
				end
				ST_SC_CMP: begin
					// strict compare keeps the lower slot on a tie
					if (!best_found_q || lhs_q > rhs_q) begin
						best_found_q <= 1'b1;
						best_idx_q <= slot;
						best_pr_q <= cand_pr_q;
						best_l_q <= cand_l_q;
						best_need_q <= cand_need_q;
						best_task_q <= cand_task_q;
					end
					idx_q <= idx_q + 1'b1;
				end
				ST_GREEDY: begin
					if (!fits) begin
						picked_q[best_idx_q] <= 1'b1;
					end else if (can_emit) begin
						picked_q[best_idx_q] <= 1'b1;
						chosen_q[best_idx_q] <= 1'b1;
						left_q <= left_q - best_need_q;
					end
				end
				ST_DONE: begin
					if (can_emit) ran_last_q <= valid_q & chosen_q;
				end
				default: ;
			endcase
		end
	end

	// comparator datapath, priority times remaining registered first, then both cross products; also the output register
	always_ff @(posedge clk) begin
		if (state_q == ST_SC_MUL1) begin
			cand_pr_q <= 24'(rd.prio * rd.remaining);
			cand_l_q <= rd.length;
			cand_need_q <= rd.need;
			cand_task_q <= rd.task_id;
		end
		if (state_q == ST_SC_MUL2) begin
			lhs_q <= 40'(cand_pr_q * best_l_q);
			rhs_q <= 40'(best_pr_q * cand_l_q);
		end
		if (emit) begin
			out_kind_q <= emit_kind;
			out_task_q <= emit_task;
			out_new_q <= emit_new;
			out_used_q <= (emit_kind == KIND_TICK) ? (total_q - left_q) : 16'd0;
			out_last_q <= (emit_kind != KIND_FINISH) && (emit_kind != KIND_RUN);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = out_kind_q;
	assign m_axis_tlast = out_last_q;
	assign m_axis_tdata = {7'd0, out_used_q, out_new_q, out_task_q};

	`RBPS_ASSERT(a_ran_last_valid, (ran_last_q & ~valid_q) == '0)
	`RBPS_ASSERT(a_chosen_valid, (chosen_q & ~valid_q) == '0)
	`RBPS_ASSERT_IMPL(a_greedy_unpicked, state_q == ST_GREEDY, !picked_q[best_idx_q])
	`RBPS_ASSERT_IMPL(a_left_in_budget, state_q != ST_IDLE, left_q <= total_q)
endmodule

### rtl/core/rbps_ram.sv
// generic single write port ram with registered read
module rbps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### tb/testbench.sv
// self-checking testbench for the resource budget scheduler
`timescale 1ns / 1ps
module testbench;
	import rbps_pkg::*;

	typedef struct {
		kind_t       kind;
		logic [7:0]  tsk;
		bit          fresh;
		logic [15:0] used;
		bit          last;
	} sched_result_t;

	class sched_scoreboard;
		logic [15:0] budget;
		bit          busy_slot [SLOTS];
		bit          ran_last [SLOTS];
		logic [7:0]  tsk_id [SLOTS];
		logic [7:0]  prio [SLOTS];
		logic [15:0] length [SLOTS];
		logic [15:0] remaining [SLOTS];
		logic [15:0] need [SLOTS];
		sched_result_t pending [$];
		int errors;

		function new();
			budget = '0;
			errors = 0;
			foreach (busy_slot[i]) begin
				busy_slot[i] = 1'b0;
				ran_last[i] = 1'b0;
			end
		endfunction

		function void push(kind_t k, logic [7:0] t, bit f, logic [15:0] u, bit l);
			sched_result_t r;
			r.kind = k; r.tsk = t; r.fresh = f; r.used = u; r.last = l;
			pending.insert(pending.size(), r);
		endfunction

		// exact comparison of prio*remaining/length by cross-multiplication
		function bit outranks(int a, int b);
			logic [63:0] lhs, rhs;
			lhs = 64'(prio[a]) * 64'(remaining[a]) * 64'(length[b]);
			rhs = 64'(prio[b]) * 64'(remaining[b]) * 64'(length[a]);
			return lhs > rhs;
		endfunction

		function void note_item(bit tick, logic [7:0] id, logic [7:0] p,
				logic [15:0] len, logic [15:0] nd);
			int order [$];
			int free_at, cur, j;
			bit chosen [SLOTS];
			logic [15:0] left;
			if (!tick) begin
				free_at = -1;
				for (int i = 0; i < SLOTS; i++)
					if (!busy_slot[i] && free_at < 0) free_at = i;
				if (len == 0 || free_at < 0) begin
					push(KIND_REJECT, id, 1'b0, 16'd0, 1'b1);
					return;
				end
				busy_slot[free_at] = 1'b1;
				tsk_id[free_at] = id;
				prio[free_at] = p;
				length[free_at] = len;
				remaining[free_at] = len;
				need[free_at] = nd;
				ran_last[free_at] = 1'b0;
				push(KIND_ACCEPT, id, 1'b0, 16'd0, 1'b1);
				return;
			end
			// charge the tasks that ran in the previous slot
			for (int i = 0; i < SLOTS; i++) begin
				if (busy_slot[i] && ran_last[i]) begin
					remaining[i] = remaining[i] - 16'd1;
					if (remaining[i] == 0) begin
						push(KIND_FINISH, tsk_id[i], 1'b0, 16'd0, 1'b0);
						busy_slot[i] = 1'b0;
						ran_last[i] = 1'b0;
					end
				end
			end
			for (int i = 0; i < SLOTS; i++) begin
				chosen[i] = 1'b0;
				if (busy_slot[i]) order.insert(order.size(), i);
			end
			// stable insertion sort, ties keep the lower slot first
			for (int i = 1; i < order.size(); i++) begin
				cur = order[i];
				j = i;
				while (j > 0 && outranks(cur, order[j-1])) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = cur;
			end
			left = budget;
			foreach (order[i]) begin
				if (need[order[i]] < left) begin
					left = left - need[order[i]];
					chosen[order[i]] = 1'b1;
					push(KIND_RUN, tsk_id[order[i]], !ran_last[order[i]], 16'd0, 1'b0);
				end
			end
			for (int i = 0; i < SLOTS; i++) ran_last[i] = busy_slot[i] && chosen[i];
			push(KIND_TICK, 8'd0, 1'b0, budget - left, 1'b1);
		endfunction

		function void check_result(kind_t k, logic [7:0] t, bit f, logic [15:0] u, bit l);
			sched_result_t e;
			if (pending.size() == 0) begin
				$error("result with nothing expected: kind %0d task %0d", k, t);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (k !== e.kind) begin
				$error("kind: expected %0d, actual %0d", e.kind, k); errors++;
			end
			if (t !== e.tsk) begin
				$error("out_task: expected %0d, actual %0d", e.tsk, t); errors++;
			end
			if (f !== e.fresh) begin
				$error("new_interval: expected %0d, actual %0d", e.fresh, f); errors++;
			end
			if (u !== e.used) begin
				$error("resources_used: expected %0d, actual %0d", e.used, u); errors++;
			end
			if (l !== e.last) begin
				$error("last: expected %0d, actual %0d", e.last, l); errors++;
			end
		endfunction
	endclass

	logic              clk = 0;
	logic              arst_n = 0;
	logic              cfg_we = 0;
	logic [15:0]       cfg_wdata = 0;
	logic              s_axis_tvalid = 0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = 0;
	logic              s_axis_tuser = 0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 0;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic [2:0]        m_axis_tuser;
	logic              m_axis_tlast;

	sched_scoreboard sb = new();
	bit calm = 0;

	resource_budget_preemptive_scheduler u_dut (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(kind_t'(m_axis_tuser), m_axis_tdata[7:0], m_axis_tdata[8],
				m_axis_tdata[24:9], m_axis_tlast);
		m_axis_tready <= calm || ($urandom_range(99) >= 32);
	end

	task automatic send_item(bit tick, logic [7:0] id, logic [7:0] p,
			logic [15:0] len, logic [15:0] nd);
		while (!calm && $urandom_range(99) < 32) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= tick;
		s_axis_tdata <= {nd, len, p, id};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(tick, id, p, len, nd);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_budget(logic [15:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.budget = v;
	endtask

	task automatic random_item();
		logic [15:0] len, nd;
		int r;
		if ($urandom_range(9) < 4) begin
			send_item(1'b1, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
			return;
		end
		r = $urandom_range(19);
		len = (r == 0) ? 16'd0 : (r == 1) ? 16'($urandom) : 16'($urandom_range(4, 1));
		nd = ($urandom_range(9) == 0) ? 16'($urandom)
			: 16'($urandom_range(sb.budget / 3 + 1));
		send_item(1'b0, 8'($urandom), 8'($urandom), len, nd);
	endtask

	initial begin
		logic [15:0] phase_budget [5] = '{16'd1, 16'd1000, 16'd65535, 16'd300, 16'd0};
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// zero budget from reset: bad length, full table, nothing can run
		send_item(1'b0, 8'hFF, 8'hFF, 16'd0, 16'hFFFF);
		send_item(1'b0, 8'h00, 8'h00, 16'hFFFF, 16'h0000);
		send_item(1'b0, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
		for (int i = 2; i < SLOTS; i++)
			send_item(1'b0, 8'(i), 8'd10, 16'(i % 3 + 1), 16'(i * 100));
		send_item(1'b0, 8'd77, 8'd5, 16'd2, 16'd1);
		send_item(1'b1, 8'd0, 8'd0, 16'd0, 16'd0);
		drain();
		// full budget, equal keys among the slots with the same weight and length
		write_budget(16'hFFFF);
		repeat (4) send_item(1'b1, 8'd0, 8'd0, 16'd0, 16'd0);
		drain();
		foreach (phase_budget[ph]) begin
			write_budget(ph == 3 ? 16'($urandom) : phase_budget[ph]);
			calm = (ph == 1);
			repeat (20) random_item();
			drain();
		end
		calm = 0;
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("resource_budget_preemptive_scheduler: match");
		else
			$display("resource_budget_preemptive_scheduler: mismatch");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("resource_budget_preemptive_scheduler: mismatch");
		$finish;
	end
endmodule

### files.f
+incdir+rtl/core
rtl/core/rbps_pkg.sv
rtl/core/rbps_ram.sv
rtl/core/resource_budget_preemptive_scheduler.sv
tb/testbench.sv
